// File: hw/rtl/pearson_correlation_engine_macros.svh
// Assertion macros used by the top-level RTL file of the correlation engine.
`ifndef PEARSON_CORRELATION_ENGINE_MACROS_SVH
`define PEARSON_CORRELATION_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define PCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pce: implication check failed");
`define PCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pce: next-cycle check failed");
`else
`define PCE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PCE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/pce_pkg.sv
`default_nettype none

package pce_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 25;
  localparam int SQ_W       = 40;
  localparam int LEN_W      = 9;
  localparam int Q_W        = 16;
  localparam int MUL_W      = 52;
  localparam int WIDE_W     = 140;
  localparam int FRAC_SHIFT = 32;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_ZERO_X   = 4'd1;

  localparam logic [Q_W-1:0] Q_NEG_ONE = 16'h8000;
  localparam logic [Q_W-1:0] Q_POS_MAX = 16'd32767;
  localparam logic [Q_W-1:0] Q_NEG_MAX = 16'd32768;

  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SQ_W-1:0]  sxy;
    logic signed [SQ_W-1:0]  sxx;
    logic signed [SQ_W-1:0]  syy;
  } acc_sums_t;

  typedef struct packed {
    logic                  done;
    logic [Q_W-1:0]        correlation;
    logic                  not_finite;
  } solve_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/pce_channels.sv
`default_nettype none

interface pce_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pce_pkg::SAMPLE_W-1:0] x_score;
  logic signed [pce_pkg::SAMPLE_W-1:0] y_score;
  logic                                last_pair;

  modport source (output valid, x_score, y_score, last_pair, input ready);
  modport sink (input valid, x_score, y_score, last_pair, output ready);
endinterface

interface pce_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [pce_pkg::Q_W-1:0] correlation;
  logic                           not_finite;

  modport source (output valid, correlation, not_finite, input ready);
  modport sink (input valid, correlation, not_finite, output ready);
endinterface

interface pce_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pce_pkg::CFG_IDX_W-1:0]    index;
  logic [pce_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pce_alu.sv
`default_nettype none

module pce_alu (
  input  logic [pce_pkg::WIDE_W-1:0] a_i,
  input  logic [pce_pkg::WIDE_W-1:0] b_i,
  input  logic                       sub_i,
  output logic [pce_pkg::WIDE_W-1:0] sum_o
);
  import pce_pkg::*;

  logic [WIDE_W-1:0] b_eff;

  assign b_eff = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_eff + WIDE_W'(sub_i);

endmodule

`default_nettype wire

// File: hw/rtl/pce_accum.sv
`default_nettype none

module pce_accum (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               add_i,
  input  logic signed [pce_pkg::SAMPLE_W-1:0] x_i,
  input  logic signed [pce_pkg::SAMPLE_W-1:0] y_i,
  input  logic                               clear_i,
  output logic                               done_o,
  output pce_pkg::acc_sums_t                 sums_o
);
  import pce_pkg::*;

  localparam logic [1:0] PH_XY = 2'd0;
  localparam logic [1:0] PH_XX = 2'd1;
  localparam logic [1:0] PH_YY = 2'd2;

  logic                       busy_q, busy_d;
  logic [1:0]                 phase_q, phase_d;
  logic                       add_q;
  logic signed [SAMPLE_W-1:0] x_q, y_q;
  logic signed [SAMPLE_W-1:0] op_a, op_b;
  logic signed [2*SAMPLE_W-1:0] prod;
  acc_sums_t                  sums_q, sums_d;

  always_comb begin
    case (phase_q)
      PH_XY: begin
        op_a = x_q;
        op_b = y_q;
      end
      PH_XX: begin
        op_a = x_q;
        op_b = x_q;
      end
      default: begin
        op_a = y_q;
        op_b = y_q;
      end
    endcase
  end

  assign prod = op_a * op_b;

  always_comb begin
    sums_d  = sums_q;
    busy_d  = busy_q;
    phase_d = phase_q;
    if (busy_q) begin
      phase_d = phase_q + 2'd1;
      if (phase_q == PH_YY) begin
        busy_d = 1'b0;
      end
      if (add_q) begin
        case (phase_q)
          PH_XY: begin
            sums_d.sx  = sums_q.sx + SUM_W'(x_q);
            sums_d.sy  = sums_q.sy + SUM_W'(y_q);
            sums_d.sxy = sums_q.sxy + SQ_W'(prod);
          end
          PH_XX: sums_d.sxx = sums_q.sxx + SQ_W'(prod);
          default: sums_d.syy = sums_q.syy + SQ_W'(prod);
        endcase
      end
    end
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = PH_XY;
    end
    if (clear_i) begin
      sums_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_XY;
      sums_q  <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      sums_q  <= sums_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      add_q <= add_i;
    end
  end

  assign done_o = busy_q && (phase_q == PH_YY);
  assign sums_o = sums_q;

endmodule

`default_nettype wire

// File: hw/rtl/pce_solver.sv
`default_nettype none

module pce_solver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           take_i,
  input  logic [pce_pkg::LEN_W-1:0]      n_i,
  input  pce_pkg::acc_sums_t             sums_i,
  output pce_pkg::solve_res_t            res_o
);
  import pce_pkg::*;

  localparam logic [2:0] SV_IDLE  = 3'd0;
  localparam logic [2:0] SV_LOAD  = 3'd1;
  localparam logic [2:0] SV_MUL   = 3'd2;
  localparam logic [2:0] SV_STORE = 3'd3;
  localparam logic [2:0] SV_SRCH  = 3'd4;
  localparam logic [2:0] SV_DONE  = 3'd5;

  localparam logic [2:0] SS_SQ    = 3'd0;
  localparam logic [2:0] SS_SQ2   = 3'd1;
  localparam logic [2:0] SS_LIN   = 3'd2;
  localparam logic [2:0] SS_DIFF  = 3'd3;
  localparam logic [2:0] SS_PLUS  = 3'd4;
  localparam logic [2:0] SS_CMP   = 3'd5;
  localparam logic [2:0] SS_STEP  = 3'd6;

  localparam logic [2:0] OP_NUM_B = 3'd1;
  localparam logic [2:0] OP_DX_B  = 3'd3;
  localparam logic [2:0] OP_DY_B  = 3'd5;
  localparam logic [2:0] OP_DEN   = 3'd6;
  localparam logic [2:0] OP_NUMSQ = 3'd7;

  localparam logic [3:0] TOP_BIT = 4'(Q_W - 1);

  logic [2:0]              st_q, st_d;
  logic [2:0]              op_q, op_d;
  logic [2:0]              ss_q, ss_d;
  logic [3:0]              bit_q, bit_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d, len_q, len_d;
  logic                    negop_q, negop_d;
  logic                    ok_q, ok_d;
  logic [WIDE_W-1:0]       acc_q, acc_d, mcand_q, mcand_d;
  logic [MUL_W-1:0]        mplier_q, mplier_d;
  logic signed [MUL_W-1:0] num_q, num_d, dx_q, dx_d;
  logic [WIDE_W-1:0]       d_q, d_d, l_q, l_d;
  logic [WIDE_W-1:0]       s_q, s_d, sp_q, sp_d, r_q, r_d, rp_q, rp_d;
  logic [WIDE_W-1:0]       u_q, u_d, v_q, v_d, dsh_q, dsh_d;
  logic [Q_W-1:0]          m_q, m_d, corr_q, corr_d;
  logic                    nf_q, nf_d;

  logic [WIDE_W-1:0] alu_a, alu_b, alu_sum;
  logic              alu_sub;
  logic              last_bit, neg, cand_ok;
  logic [Q_W-1:0]    cand, hi, m_new;

  pce_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  assign last_bit = (cnt_q == len_q - CNT_W'(1));
  assign neg      = num_q[MUL_W-1];
  assign hi       = neg ? Q_NEG_MAX : Q_POS_MAX;
  assign cand     = m_q | (Q_W'(1) << bit_q);
  assign cand_ok  = (cand <= hi);
  assign m_new    = ok_q ? cand : m_q;

  always_comb begin
    alu_a   = acc_q;
    alu_b   = mcand_q;
    alu_sub = 1'b0;
    if (st_q == SV_MUL) begin
      alu_sub = negop_q ^ last_bit;
    end else if (st_q == SV_SRCH) begin
      case (ss_q)
        SS_SQ: begin
          alu_a = s_q;
          alu_b = u_q;
        end
        SS_SQ2: begin
          alu_a = sp_q;
          alu_b = v_q;
        end
        SS_LIN: begin
          alu_a = r_q;
          alu_b = dsh_q;
        end
        SS_DIFF: begin
          alu_a   = sp_q << 2;
          alu_b   = rp_q << 2;
          alu_sub = 1'b1;
        end
        SS_PLUS: begin
          alu_a = acc_q;
          alu_b = d_q;
        end
        SS_CMP: begin
          alu_a   = l_q;
          alu_b   = acc_q;
          alu_sub = 1'b1;
        end
        default: begin
          alu_a = u_q;
          alu_b = v_q << 1;
        end
      endcase
    end
  end

  always_comb begin
    st_d     = st_q;
    op_d     = op_q;
    ss_d     = ss_q;
    bit_d    = bit_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    negop_d  = negop_q;
    ok_d     = ok_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    num_d    = num_q;
    dx_d     = dx_q;
    d_d      = d_q;
    l_d      = l_q;
    s_d      = s_q;
    sp_d     = sp_q;
    r_d      = r_q;
    rp_d     = rp_q;
    u_d      = u_q;
    v_d      = v_q;
    dsh_d    = dsh_q;
    m_d      = m_q;
    corr_d   = corr_q;
    nf_d     = nf_q;
    case (st_q)
      SV_IDLE: begin
        if (start_i) begin
          op_d = 3'd0;
          st_d = SV_LOAD;
        end
      end
      SV_LOAD: begin
        // The first three pairs of operations form n*S - A*B; the odd one of each subtracts.
        cnt_d   = '0;
        negop_d = op_q[0] && (op_q != OP_NUMSQ);
        if (!op_q[0] || (op_q == OP_NUMSQ)) begin
          acc_d = '0;
        end
        case (op_q)
          3'd0: begin
            mcand_d  = WIDE_W'($signed(sums_i.sxy));
            mplier_d = MUL_W'(n_i);
            len_d    = CNT_W'(LEN_W + 1);
          end
          3'd1: begin
            mcand_d  = WIDE_W'($signed(sums_i.sx));
            mplier_d = MUL_W'($signed(sums_i.sy));
            len_d    = CNT_W'(SUM_W);
          end
          3'd2: begin
            mcand_d  = WIDE_W'($signed(sums_i.sxx));
            mplier_d = MUL_W'(n_i);
            len_d    = CNT_W'(LEN_W + 1);
          end
          3'd3: begin
            mcand_d  = WIDE_W'($signed(sums_i.sx));
            mplier_d = MUL_W'($signed(sums_i.sx));
            len_d    = CNT_W'(SUM_W);
          end
          3'd4: begin
            mcand_d  = WIDE_W'($signed(sums_i.syy));
            mplier_d = MUL_W'(n_i);
            len_d    = CNT_W'(LEN_W + 1);
          end
          3'd5: begin
            mcand_d  = WIDE_W'($signed(sums_i.sy));
            mplier_d = MUL_W'($signed(sums_i.sy));
            len_d    = CNT_W'(SUM_W);
          end
          3'd6: begin
            mcand_d  = WIDE_W'(dx_q);
            mplier_d = acc_q[MUL_W-1:0];
            len_d    = CNT_W'(MUL_W);
          end
          default: begin
            mcand_d  = WIDE_W'(num_q);
            mplier_d = num_q;
            len_d    = CNT_W'(MUL_W);
          end
        endcase
        st_d = SV_MUL;
      end
      SV_MUL: begin
        // Shift-add over the multiplier bits; the top bit carries negative weight.
        if (mplier_q[0]) begin
          acc_d = alu_sum;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + CNT_W'(1);
        if (last_bit) begin
          st_d = SV_STORE;
        end
      end
      SV_STORE: begin
        st_d = SV_LOAD;
        op_d = op_q + 3'd1;
        case (op_q)
          OP_NUM_B: num_d = acc_q[MUL_W-1:0];
          OP_DX_B:  dx_d  = acc_q[MUL_W-1:0];
          OP_DY_B: begin
            // The y-term difference stays in acc_q for the next load.
            if (dx_q[MUL_W-1] || (dx_q == '0) || acc_q[WIDE_W-1] || (acc_q == '0)) begin
              corr_d = Q_NEG_ONE;
              nf_d   = 1'b1;
              st_d   = SV_DONE;
            end
          end
          OP_DEN: d_d = acc_q;
          OP_NUMSQ: begin
            l_d   = acc_q << FRAC_SHIFT;
            s_d   = '0;
            r_d   = '0;
            u_d   = '0;
            v_d   = d_q << (2 * (Q_W - 1));
            dsh_d = d_q << (Q_W - 1);
            m_d   = '0;
            bit_d = TOP_BIT;
            ss_d  = SS_SQ;
            st_d  = SV_SRCH;
          end
          default: ;
        endcase
      end
      SV_SRCH: begin
        // Trial m' = m + 2^b: test (2m'-1)^2 * D <= 2^32 * num^2.
        ss_d = ss_q + 3'd1;
        case (ss_q)
          SS_SQ:   sp_d  = alu_sum;
          SS_SQ2:  sp_d  = alu_sum;
          SS_LIN:  rp_d  = alu_sum;
          SS_DIFF: acc_d = alu_sum;
          SS_PLUS: acc_d = alu_sum;
          SS_CMP:  ok_d  = !alu_sum[WIDE_W-1] && cand_ok;
          default: begin
            if (ok_q) begin
              s_d = sp_q;
              r_d = rp_q;
            end
            m_d   = m_new;
            u_d   = ok_q ? (alu_sum >> 1) : (u_q >> 1);
            v_d   = v_q >> 2;
            dsh_d = dsh_q >> 1;
            bit_d = bit_q - 4'd1;
            ss_d  = SS_SQ;
            if (bit_q == '0) begin
              corr_d = neg ? (Q_W'(0) - m_new) : m_new;
              nf_d   = 1'b0;
              st_d   = SV_DONE;
            end
          end
        endcase
      end
      SV_DONE: begin
        if (take_i) begin
          st_d = SV_IDLE;
        end
      end
      default: st_d = SV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SV_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    ss_q     <= ss_d;
    bit_q    <= bit_d;
    cnt_q    <= cnt_d;
    len_q    <= len_d;
    negop_q  <= negop_d;
    ok_q     <= ok_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    num_q    <= num_d;
    dx_q     <= dx_d;
    d_q      <= d_d;
    l_q      <= l_d;
    s_q      <= s_d;
    sp_q     <= sp_d;
    r_q      <= r_d;
    rp_q     <= rp_d;
    u_q      <= u_d;
    v_q      <= v_d;
    dsh_q    <= dsh_d;
    m_q      <= m_d;
    corr_q   <= corr_d;
    nf_q     <= nf_d;
  end

  assign res_o.done        = (st_q == SV_DONE);
  assign res_o.correlation = corr_q;
  assign res_o.not_finite  = nf_q;

endmodule

`default_nettype wire

// File: hw/rtl/pearson_correlation_engine.sv
// Channel | Dir | Payload                               | Handshake
// in_i    | in  | x_score, y_score, last_pair           | valid / ready
// out_o   | out | correlation, not_finite               | valid / ready
// cfg_i   | in  | index (0 vector_length, 1 skip_zero_x), data | valid / ready
//
// A pair that is not the last of its vector is accepted, then the products x*y, x*x and
// y*y go in turn through the single 16x16 multiplier before the next pair is taken.
// A last pair then also needs six shift-add products, a 52-bit product and a 52-bit
// square through one 140-bit adder, then a 16-step digit search.
// An x or y term that is not positive ends the solve after the six products.
// Reset clears the sums and the output valid flag; a held result does not stop the next vector's pairs.
`default_nettype none

`include "pearson_correlation_engine_macros.svh"

module pearson_correlation_engine #(
  parameter int MAX_LENGTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pce_in_if.sink     in_i,
  pce_out_if.source  out_o,
  pce_cfg_if.sink    cfg_i
);
  import pce_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ACC   = 2'd1;
  localparam logic [1:0] ST_SOLVE = 2'd2;

  localparam logic [LEN_W-1:0] VL_RESET = LEN_W'(MAX_LENGTH);

  logic [1:0]       st_q, st_d;
  logic [LEN_W-1:0] vl_q;
  logic             skip_q;
  logic             last_q;
  logic             out_valid_q;
  logic [Q_W-1:0]   corr_q;
  logic             nf_q;

  logic       in_fire, acc_done, solve_start, out_load, skip_item;
  acc_sums_t  sums;
  solve_res_t solve_res;

  assign in_i.ready  = (st_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign skip_item   = skip_q && (in_i.x_score == '0);
  assign solve_start = (st_q == ST_ACC) && acc_done && last_q;
  assign out_load    = (st_q == ST_SOLVE) && solve_res.done && (!out_valid_q || out_o.ready);

  pce_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .add_i   (!skip_item),
    .x_i     (in_i.x_score),
    .y_i     (in_i.y_score),
    .clear_i (out_load),
    .done_o  (acc_done),
    .sums_o  (sums)
  );

  pce_solver u_solver (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (solve_start),
    .take_i  (out_load),
    .n_i     (vl_q),
    .sums_i  (sums),
    .res_o   (solve_res)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          st_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (acc_done) begin
          st_d = last_q ? ST_SOLVE : ST_IDLE;
        end
      end
      ST_SOLVE: begin
        if (out_load) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      vl_q        <= VL_RESET;
      skip_q      <= 1'b1;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (in_fire) begin
        last_q <= in_i.last_pair;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_VECTOR_LENGTH: vl_q   <= cfg_i.data[LEN_W-1:0];
          REG_SKIP_ZERO_X:   skip_q <= cfg_i.data[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      corr_q <= solve_res.correlation;
      nf_q   <= solve_res.not_finite;
    end
  end

  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.correlation = corr_q;
  assign out_o.not_finite  = nf_q;

  `PCE_ASSERT_NEXT(a_accept_starts_accum, clk_i, rst_ni, in_fire, st_q == ST_ACC)
  `PCE_ASSERT_IMPL(a_not_finite_reads_neg_one, clk_i, rst_ni,
                   solve_res.done && solve_res.not_finite, solve_res.correlation == Q_NEG_ONE)
  `PCE_ASSERT_NEXT(a_load_frees_input, clk_i, rst_ni, out_load,
                   out_valid_q && (st_q == ST_IDLE))

endmodule

`default_nettype wire
